### src/abs_pkg.sv
// shared types, codes and reset values for the alert beacon sequencer
// no dependencies; used by the interfaces and every module of the block
package abs_pkg;

   localparam int REQ_TYPE_W = 3;
   localparam int TIME_W     = 32;
   localparam int BITS_W     = 16;
   localparam int LAT_W      = 21;
   localparam int LON_W      = 22;
   localparam int CODE_W     = 16;
   localparam int DUR_W      = 22;
   localparam int CNT16_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TRIGGER  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET_BITS = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET_POS  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_CANCEL   = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_SHUTDOWN = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BEACON_ID     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_MASK     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_MASK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DURATION  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SENDS     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_OFFSET    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LON_OFFSET    = 3'd7;

   // register reset values
   localparam logic [BITS_W-1:0]       RST_BEACON_ID    = 16'd0;
   localparam logic [BITS_W-1:0]       RST_AUTO_MASK    = 16'hFFFF;
   localparam logic [BITS_W-1:0]       RST_LOCK_MASK    = 16'd2;
   localparam logic [CNT16_W-1:0]      RST_INTERVAL     = 16'd500;
   localparam logic [DUR_W-1:0]        RST_MIN_DURATION = 22'd30000;
   localparam logic [CNT16_W-1:0]      RST_MIN_SENDS    = 16'd60;
   localparam logic signed [LAT_W-1:0] RST_LAT_OFFSET   = 21'sd330000;
   localparam logic signed [LON_W-1:0] RST_LON_OFFSET   = 22'sd1240000;

   // coordinate compression: floor(diff * 6554 / 65536), saturated
   localparam int                     SCALE_W     = 14;
   localparam logic signed [SCALE_W-1:0] COORD_SCALE = 14'sd6554;
   localparam int                     SCALE_SHIFT = 16;
   localparam logic signed [CODE_W-1:0]  CODE_MAX = 16'sh7FFF;
   localparam logic signed [CODE_W-1:0]  CODE_MIN = 16'sh8000;

   typedef struct packed {
      logic [BITS_W-1:0]       beacon_id;
      logic [BITS_W-1:0]       auto_start_mask;
      logic [BITS_W-1:0]       cancel_lock_mask;
      logic [CNT16_W-1:0]      send_interval_ms;
      logic [DUR_W-1:0]        min_active_ms;
      logic [CNT16_W-1:0]      min_send_count;
      logic signed [LAT_W-1:0] lat_offset_e4;
      logic signed [LON_W-1:0] lon_offset_e4;
   } cfg_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]   req_type;
      logic [TIME_W-1:0]       now_ms;
      logic [BITS_W-1:0]       flag_bits;
      logic signed [LAT_W-1:0] latitude_e4;
      logic signed [LON_W-1:0] longitude_e4;
   } req_item_type;

   typedef struct packed {
      logic                     pkt_valid;
      logic [BITS_W-1:0]        pkt_beacon_id;
      logic [BITS_W-1:0]        pkt_alert_bits;
      logic signed [CODE_W-1:0] pkt_lat_code;
      logic signed [CODE_W-1:0] pkt_lon_code;
      logic                     beacon_on;
      logic [BITS_W-1:0]        alert_bits_now;
   } rsp_item_type;

endpackage

### src/abs_if.sv
// request, result and register write channels of the alert beacon sequencer
// depends on abs_pkg for field widths
interface abs_req_if;
   import abs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [TIME_W-1:0]       now_ms;
   logic [BITS_W-1:0]       flag_bits;
   logic signed [LAT_W-1:0] latitude_e4;
   logic signed [LON_W-1:0] longitude_e4;

   modport source (output valid, req_type, now_ms, flag_bits, latitude_e4, longitude_e4,
                   input ready);
   modport sink (input valid, req_type, now_ms, flag_bits, latitude_e4, longitude_e4,
                 output ready);
endinterface

interface abs_rsp_if;
   import abs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     pkt_valid;
   logic [BITS_W-1:0]        pkt_beacon_id;
   logic [BITS_W-1:0]        pkt_alert_bits;
   logic signed [CODE_W-1:0] pkt_lat_code;
   logic signed [CODE_W-1:0] pkt_lon_code;
   logic                     beacon_on;
   logic [BITS_W-1:0]        alert_bits_now;

   modport source (output valid, pkt_valid, pkt_beacon_id, pkt_alert_bits, pkt_lat_code,
                   pkt_lon_code, beacon_on, alert_bits_now, input ready);
   modport sink (input valid, pkt_valid, pkt_beacon_id, pkt_alert_bits, pkt_lat_code,
                 pkt_lon_code, beacon_on, alert_bits_now, output ready);
endinterface

interface abs_csr_if;
   import abs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/abs_coord_code.sv
// coordinate compression: (x - offset) * 6554 >> 16, saturated to 16 bits signed
// depends on abs_pkg for the scale and saturation constants
module abs_coord_code #(
   parameter int XW = abs_pkg::LAT_W
) (
   input  logic signed [XW-1:0]               x,
   input  logic signed [XW-1:0]               off,
   output logic signed [abs_pkg::CODE_W-1:0]  code
);
   import abs_pkg::*;

   localparam int DIFF_W = XW + 1;
   localparam int PROD_W = DIFF_W + SCALE_W;
   localparam int Q_W    = PROD_W - SCALE_SHIFT;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [Q_W-1:0]    quot;
   logic                     in_range;

   always_comb begin
      diff = DIFF_W'(x) - DIFF_W'(off);
      prod = PROD_W'(diff) * PROD_W'(COORD_SCALE);
      // arithmetic shift gives the floor for negative products
      quot = Q_W'(prod >>> SCALE_SHIFT);
      // fits when all bits above the code's sign agree
      in_range = (quot[Q_W-1:CODE_W-1] == '0) || (quot[Q_W-1:CODE_W-1] == '1);
      if (in_range) begin
         code = quot[CODE_W-1:0];
      end else if (quot[Q_W-1]) begin
         code = CODE_MIN;
      end else begin
         code = CODE_MAX;
      end
   end

endmodule

### src/abs_event_core.sv
// beacon state and the per-request update: timing, alert bits, cancel and packet build
// depends on abs_pkg and abs_coord_code
module abs_event_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  abs_pkg::cfg_type      cfg,
   input  abs_pkg::req_item_type item,
   output abs_pkg::rsp_item_type rsp
);
   import abs_pkg::*;

   logic                    active_ff, active_in;
   logic                    first_ff, first_in;
   logic [BITS_W-1:0]       bits_ff, bits_in;
   logic signed [LAT_W-1:0] lat_ff, lat_in;
   logic signed [LON_W-1:0] lon_ff, lon_in;
   logic [TIME_W-1:0]       start_ff, start_in;
   logic [TIME_W-1:0]       last_ff, last_in;
   logic [TIME_W-1:0]       count_ff, count_in;

   logic signed [CODE_W-1:0] lat_code;
   logic signed [CODE_W-1:0] lon_code;
   logic [TIME_W-1:0]        interval;
   logic [TIME_W-1:0]        since_send;
   logic [TIME_W-1:0]        since_start;
   logic                     send;
   logic                     expired;

   abs_coord_code #(.XW(LAT_W)) u_lat_code (
      .x    (lat_ff),
      .off  (cfg.lat_offset_e4),
      .code (lat_code)
   );

   abs_coord_code #(.XW(LON_W)) u_lon_code (
      .x    (lon_ff),
      .off  (cfg.lon_offset_e4),
      .code (lon_code)
   );

   always_comb begin
      active_in = active_ff;
      first_in  = first_ff;
      bits_in   = bits_ff;
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      rsp       = '0;

      interval    = TIME_W'(cfg.send_interval_ms);
      since_send  = item.now_ms - last_ff;
      // the first tick after a start sends at once and has zero elapsed time
      since_start = first_ff ? '0 : (item.now_ms - start_ff);
      send        = first_ff || (since_send >= interval);
      expired     = (since_start >= TIME_W'(cfg.min_active_ms)) && (bits_ff == '0);

      unique case (item.req_type)
         REQ_TICK: begin
            if (active_ff) begin
               first_in = 1'b0;
               if (first_ff) begin
                  start_in = item.now_ms;
               end
               if (send) begin
                  rsp.pkt_valid      = 1'b1;
                  rsp.pkt_beacon_id  = cfg.beacon_id;
                  rsp.pkt_alert_bits = bits_ff;
                  rsp.pkt_lat_code   = lat_code;
                  rsp.pkt_lon_code   = lon_code;
                  // phase locked to the first send: advance by exactly one interval
                  last_in  = first_ff ? item.now_ms : (last_ff + interval);
                  count_in = count_ff + 1'b1;
                  if (expired) begin
                     active_in = 1'b0;
                     count_in  = '0;
                  end
               end
            end
         end
         REQ_TRIGGER: begin
            bits_in = bits_ff | item.flag_bits;
            if (!active_ff && ((item.flag_bits & cfg.auto_start_mask) != '0)) begin
               active_in = 1'b1;
               first_in  = 1'b1;
               start_in  = '0;
               last_in   = '0;
               count_in  = '0;
            end
         end
         REQ_SET_BITS: begin
            bits_in = item.flag_bits;
         end
         REQ_SET_POS: begin
            lat_in = item.latitude_e4;
            lon_in = item.longitude_e4;
         end
         REQ_CANCEL: begin
            if ((bits_ff & cfg.cancel_lock_mask) == '0) begin
               bits_in = '0;
               if (count_ff >= TIME_W'(cfg.min_send_count)) begin
                  active_in = 1'b0;
                  count_in  = '0;
               end
            end
         end
         REQ_SHUTDOWN: begin
            active_in = 1'b0;
            bits_in   = '0;
         end
         default: begin
         end
      endcase

      rsp.beacon_on      = active_in;
      rsp.alert_bits_now = bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         first_ff  <= 1'b0;
         bits_ff   <= '0;
         lat_ff    <= '0;
         lon_ff    <= '0;
         start_ff  <= '0;
         last_ff   <= '0;
         count_ff  <= '0;
      end else if (go) begin
         active_ff <= active_in;
         first_ff  <= first_in;
         bits_ff   <= bits_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         start_ff  <= start_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/alert_beacon_sequencer.sv
// alert beacon sequencer top level: request register, register file, result register
// depends on abs_pkg, abs_if and abs_event_core
// a request is held in the request register, and its result in the result register
// one request per cycle unless a result stalls; the request register refills while one waits
// the core path: 22x14 and 23x14 multipliers for the coordinate codes, beside 32-bit compares
// synchronous active-high reset: beacon idle, alert bits, position, times and count zero,
// registers at their default values, both channels empty
module alert_beacon_sequencer (
   input  logic             clock,
   input  logic             reset,
   abs_req_if.sink          req_ch,
   abs_rsp_if.source        rsp_ch,
   abs_csr_if.sink          csr_ch
);
   import abs_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item;
   cfg_type      cfg_ff, cfg_in;
   logic         out_free;
   logic         go;
   logic         req_take;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign go           = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BEACON_ID:    cfg_in.beacon_id        = csr_ch.data[BITS_W-1:0];
            CSR_AUTO_MASK:    cfg_in.auto_start_mask  = csr_ch.data[BITS_W-1:0];
            CSR_LOCK_MASK:    cfg_in.cancel_lock_mask = csr_ch.data[BITS_W-1:0];
            CSR_INTERVAL:     cfg_in.send_interval_ms = csr_ch.data[CNT16_W-1:0];
            CSR_MIN_DURATION: cfg_in.min_active_ms    = csr_ch.data[DUR_W-1:0];
            CSR_MIN_SENDS:    cfg_in.min_send_count   = csr_ch.data[CNT16_W-1:0];
            CSR_LAT_OFFSET:   cfg_in.lat_offset_e4    = csr_ch.data[LAT_W-1:0];
            CSR_LON_OFFSET:   cfg_in.lon_offset_e4    = csr_ch.data[LON_W-1:0];
            default: begin
            end
         endcase
      end
   end

   abs_event_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .cfg   (cfg_ff),
      .item  (in_item_ff),
      .rsp   (rsp_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.beacon_id        <= RST_BEACON_ID;
         cfg_ff.auto_start_mask  <= RST_AUTO_MASK;
         cfg_ff.cancel_lock_mask <= RST_LOCK_MASK;
         cfg_ff.send_interval_ms <= RST_INTERVAL;
         cfg_ff.min_active_ms    <= RST_MIN_DURATION;
         cfg_ff.min_send_count   <= RST_MIN_SENDS;
         cfg_ff.lat_offset_e4    <= RST_LAT_OFFSET;
         cfg_ff.lon_offset_e4    <= RST_LON_OFFSET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.req_type     <= req_ch.req_type;
         in_item_ff.now_ms       <= req_ch.now_ms;
         in_item_ff.flag_bits    <= req_ch.flag_bits;
         in_item_ff.latitude_e4  <= req_ch.latitude_e4;
         in_item_ff.longitude_e4 <= req_ch.longitude_e4;
      end
      if (go) begin
         rsp_item_ff <= rsp_item;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pkt_valid      = rsp_item_ff.pkt_valid;
   assign rsp_ch.pkt_beacon_id  = rsp_item_ff.pkt_beacon_id;
   assign rsp_ch.pkt_alert_bits = rsp_item_ff.pkt_alert_bits;
   assign rsp_ch.pkt_lat_code   = rsp_item_ff.pkt_lat_code;
   assign rsp_ch.pkt_lon_code   = rsp_item_ff.pkt_lon_code;
   assign rsp_ch.beacon_on      = rsp_item_ff.beacon_on;
   assign rsp_ch.alert_bits_now = rsp_item_ff.alert_bits_now;

endmodule

### src/abs_checker.sv
// port-level checks on the result channel of the alert beacon sequencer, and their bind
// depends on abs_pkg and alert_beacon_sequencer
module abs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              pkt_valid,
   input logic [abs_pkg::BITS_W-1:0]        pkt_beacon_id,
   input logic [abs_pkg::BITS_W-1:0]        pkt_alert_bits,
   input logic signed [abs_pkg::CODE_W-1:0] pkt_lat_code,
   input logic signed [abs_pkg::CODE_W-1:0] pkt_lon_code,
   input logic                              beacon_on,
   input logic [abs_pkg::BITS_W-1:0]        alert_bits_now
);
   import abs_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pkt_valid) && $stable(pkt_alert_bits)
         && $stable(beacon_on) && $stable(alert_bits_now))
      else $error("stalled result changed");

   // no packet means empty packet fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pkt_valid |-> pkt_beacon_id == '0 && pkt_alert_bits == '0
         && pkt_lat_code == '0 && pkt_lon_code == '0)
      else $error("packet fields set without a packet");

   // a tick never changes the alert bits, so the packet carries the current ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pkt_valid |-> pkt_alert_bits == alert_bits_now)
      else $error("packet alert bits differ from current bits");

   // the beacon only stops at a send once the bits are clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pkt_valid && pkt_alert_bits != '0 |-> beacon_on)
      else $error("beacon stopped with alert bits set");

   // reset empties the result channel
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind alert_beacon_sequencer abs_checker u_abs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .pkt_valid      (rsp_ch.pkt_valid),
   .pkt_beacon_id  (rsp_ch.pkt_beacon_id),
   .pkt_alert_bits (rsp_ch.pkt_alert_bits),
   .pkt_lat_code   (rsp_ch.pkt_lat_code),
   .pkt_lon_code   (rsp_ch.pkt_lon_code),
   .beacon_on      (rsp_ch.beacon_on),
   .alert_bits_now (rsp_ch.alert_bits_now)
);
